[src/pf_pkg.sv]
// ----------------------------------------------------------------------------
// pf_pkg: shared definitions for the prime factorization core
// Microcode format, operation and condition codes, and the control program.
// ----------------------------------------------------------------------------
package pf_pkg;

	localparam int DataBitsDefault = 32;

	localparam int StepBits = 4;

	typedef logic [StepBits-1:0] step_t;

	// Datapath operations.
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_ACCEPT    = 4'd1;
	localparam logic [3:0] OP_DSTART    = 4'd2;
	localparam logic [3:0] OP_DWAIT     = 4'd3;
	localparam logic [3:0] OP_FOUND     = 4'd4;
	localparam logic [3:0] OP_INC       = 4'd5;
	localparam logic [3:0] OP_PUSH      = 4'd6;
	localparam logic [3:0] OP_EMITLAST  = 4'd7;
	localparam logic [3:0] OP_EMITNONE  = 4'd8;

	// Jump conditions.
	localparam logic [2:0] C_NEVER  = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_BAD    = 3'd2;
	localparam logic [2:0] C_QLT    = 3'd3;
	localparam logic [2:0] C_RNZ    = 3'd4;
	localparam logic [2:0] C_NLE1   = 3'd5;

	// Program addresses.
	localparam step_t S_ACCEPT = 4'd0;
	localparam step_t S_DSTART = 4'd1;
	localparam step_t S_DWAIT  = 4'd2;
	localparam step_t S_TEST   = 4'd3;
	localparam step_t S_FOUND  = 4'd4;
	localparam step_t S_NEXT   = 4'd5;
	localparam step_t S_FIN    = 4'd6;
	localparam step_t S_PUSH   = 4'd7;
	localparam step_t S_LAST   = 4'd8;
	localparam step_t S_NONE   = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] cond;
		step_t      target;
	} ctrl_t;

	// Control store. A step whose operation is not ready holds; otherwise it
	// performs the operation and jumps to target when cond holds, else falls
	// through to the next step.
	function automatic ctrl_t pf_rom(input step_t s);
		ctrl_t w;
		case (s)
			S_ACCEPT: w = '{OP_ACCEPT,   C_BAD,    S_NONE};
			S_DSTART: w = '{OP_DSTART,   C_NEVER,  S_ACCEPT};
			S_DWAIT:  w = '{OP_DWAIT,    C_QLT,    S_FIN};
			S_TEST:   w = '{OP_NOP,      C_RNZ,    S_NEXT};
			S_FOUND:  w = '{OP_FOUND,    C_ALWAYS, S_DSTART};
			S_NEXT:   w = '{OP_INC,      C_ALWAYS, S_DSTART};
			S_FIN:    w = '{OP_NOP,      C_NLE1,   S_LAST};
			S_PUSH:   w = '{OP_PUSH,     C_NEVER,  S_ACCEPT};
			S_LAST:   w = '{OP_EMITLAST, C_ALWAYS, S_ACCEPT};
			S_NONE:   w = '{OP_EMITNONE, C_ALWAYS, S_ACCEPT};
			default:  w = '{OP_NOP,      C_ALWAYS, S_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

[src/pf_div.sv]
// ----------------------------------------------------------------------------
// pf_div: restoring unsigned divider
// Produces one quotient bit per cycle; quotient and remainder hold when done.
// ----------------------------------------------------------------------------
module pf_div import pf_pkg::*; #(
	parameter int N = DataBitsDefault - 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [N-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quotient,
	output logic [N-1:0] remainder
);

	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  rem_q;
	logic [N-1:0]  quo_q;
	logic [N-1:0]  dsr_q;
	logic [N:0]    trial;

	assign trial = {rem_q, quo_q[N-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// A clear borrow bit means the divisor fit into the partial remainder.
			if (!trial[N]) begin
				rem_q <= trial[N-1:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[N-2:0], quo_q[N-1]};
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[src/prime_factorization_core.sv]
// ----------------------------------------------------------------------------
// prime_factorization_core: trial-division prime factorizer
// Emits the prime factors of each input word in ascending order.
// ----------------------------------------------------------------------------
// One input word is taken at a time. Each trial divisor costs one division in
// the shared restoring divider plus about four microcode steps, and up to
// sqrt(value) divisors are tried, so a large prime takes far longer than a
// small or smooth input. Factors leave one word each through an output
// register; the final word has last set, and an input below 2 gives a single
// word with none set and factor zero.
module prime_factorization_core import pf_pkg::*; #(
	parameter int DATA_BITS = DataBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [DATA_BITS-1:0] value,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [DATA_BITS-2:0] factor,
	output logic                 last,
	output logic                 none
);

	localparam int N = DATA_BITS - 1;

	step_t        step_q;
	ctrl_t        cw;
	logic         go;
	logic         jump;
	logic         slot_free;
	logic         bad;

	logic [N-1:0] n_q;
	logic [N-1:0] d_q;
	logic [N-1:0] pend_q;
	logic         pend_v_q;

	logic         res_v_q;
	logic [N-1:0] res_factor_q;
	logic         res_last_q;
	logic         res_none_q;

	logic         div_start;
	logic         div_busy;
	logic [N-1:0] div_q;
	logic [N-1:0] div_r;

	logic         emit;
	logic [N-1:0] emit_factor;
	logic         emit_last;
	logic         emit_none;

	assign cw        = pf_rom(step_q);
	assign slot_free = !res_v_q || !result_stall;
	assign bad       = value[DATA_BITS-1] || (value[N-1:0] < N'(2));

	always_comb begin
		case (cw.op)
			OP_ACCEPT:   go = item_valid;
			OP_DWAIT:    go = !div_busy;
			OP_FOUND,
			OP_PUSH:     go = !pend_v_q || slot_free;
			OP_EMITLAST,
			OP_EMITNONE: go = slot_free;
			default:     go = 1'b1;
		endcase
	end

	always_comb begin
		case (cw.cond)
			C_ALWAYS: jump = 1'b1;
			C_BAD:    jump = bad;
			C_QLT:    jump = div_q < d_q;
			C_RNZ:    jump = div_r != '0;
			C_NLE1:   jump = n_q <= N'(1);
			default:  jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= S_ACCEPT;
		else if (go)
			step_q <= jump ? cw.target : step_q + 1'b1;
	end

	assign item_stall = (step_q != S_ACCEPT);
	assign div_start  = (cw.op == OP_DSTART);

	pf_div #(.N(N)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.busy      (div_busy),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// A found factor is held back one place so the last mark can be set on
	// whichever word turns out to be final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (go) begin
			case (cw.op)
				OP_ACCEPT:            pend_v_q <= 1'b0;
				OP_FOUND, OP_PUSH:    pend_v_q <= 1'b1;
				default:              pend_v_q <= pend_v_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (cw.op)
				OP_ACCEPT: begin
					n_q <= value[N-1:0];
					d_q <= N'(2);
				end
				OP_FOUND: begin
					pend_q <= d_q;
					n_q    <= div_q;
				end
				OP_INC:  d_q    <= d_q + 1'b1;
				OP_PUSH: pend_q <= n_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		emit        = 1'b0;
		emit_factor = pend_q;
		emit_last   = 1'b0;
		emit_none   = 1'b0;
		if (go) begin
			case (cw.op)
				OP_FOUND, OP_PUSH: emit = pend_v_q;
				OP_EMITLAST: begin
					emit      = 1'b1;
					emit_last = 1'b1;
				end
				OP_EMITNONE: begin
					emit        = 1'b1;
					emit_last   = 1'b1;
					emit_none   = 1'b1;
					emit_factor = '0;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (emit)
			res_v_q <= 1'b1;
		else if (!result_stall)
			res_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_factor_q <= emit_factor;
			res_last_q   <= emit_last;
			res_none_q   <= emit_none;
		end
	end

	assign result_valid = res_v_q;
	assign factor       = res_factor_q;
	assign last         = res_last_q;
	assign none         = res_none_q;

endmodule

[src/pf_checker.sv]
// ----------------------------------------------------------------------------
// pf_checker: port-level assertions for the prime factorization core
// Watches the handshakes and result words of the top level.
// ----------------------------------------------------------------------------
module pf_checker import pf_pkg::*; #(
	parameter int DATA_BITS = DataBitsDefault
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic [DATA_BITS-1:0] value,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [DATA_BITS-2:0] factor,
	input logic                 last,
	input logic                 none
);

	// A waiting result word must hold until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(factor)
			&& $stable(last) && $stable(none))
		else $error("result word changed while stalled");

	// Only one input word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second word accepted while busy");

	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none |-> last && (factor == '0))
		else $error("none word must be final with a zero factor");

	a_factor_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !none |-> factor >= (DATA_BITS-1)'(2))
		else $error("factor below two");

	// Every result word is fully known while it is offered.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$isunknown({factor, last, none}))
		else $error("result word has unknown bits");

endmodule

bind prime_factorization_core pf_checker #(.DATA_BITS(DATA_BITS)) u_pf_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for prime_factorization_core
// Drives signed words through the valid/stall input and checks every factor
// word that comes out against a trial-division predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
	import pf_pkg::*;

	localparam int DW = DataBitsDefault;
	localparam int RandomWords = 92;
	localparam int DirectedWords = 18;
	localparam longint unsigned CycleLimit = 12_000_000;
	localparam longint unsigned MaxPositive = 64'h7FFF_FFFF;

	typedef struct packed {
		logic [DW-2:0] factor;
		logic          last;
		logic          none;
	} factor_word_t;

	typedef struct packed {
		logic [DW-1:0] value;
		logic          typed;
		logic [DW-2:0] factor;
		logic          none;
	} directed_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          item_valid = 1'b0;
	logic          item_stall;
	logic [DW-1:0] value = '0;
	logic          result_valid;
	logic          result_stall = 1'b0;
	logic [DW-2:0] factor;
	logic          last;
	logic          none;

	factor_word_t    expected_factors [$];
	directed_row_t   directed_rows [DirectedWords];
	int unsigned     send_idle_pct = 31;
	int unsigned     recv_stall_pct = 66;
	bit              hold_request = 1'b0;
	int unsigned     words_sent = 0;
	int unsigned     factors_checked = 0;
	int unsigned     mismatches = 0;
	longint unsigned cycle_count = 0;

	prime_factorization_core #(.DATA_BITS(DW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.factor       (factor),
		.last         (last),
		.none         (none)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Timed out after %0d cycles with %0d factor words outstanding.",
				cycle_count, expected_factors.size());
			$display("[prime_factorization_core] ERROR");
			$finish;
		end
	end

	// Appends the factor words that trial division gives for one input word.
	task automatic push_factorization(input logic [DW-1:0] v);
		longint unsigned rem;
		longint unsigned d;
		factor_word_t    w;
		if (v[DW-1] || v < 2) begin
			expected_factors.push_back('{factor: '0, last: 1'b1, none: 1'b1});
			return;
		end
		rem = v;
		d = 2;
		while (d <= rem / d) begin
			while (rem % d == 0) begin
				w = '{factor: d[DW-2:0], last: 1'b0, none: 1'b0};
				expected_factors.push_back(w);
				rem = rem / d;
			end
			d++;
		end
		if (rem > 1) begin
			w = '{factor: rem[DW-2:0], last: 1'b0, none: 1'b0};
			expected_factors.push_back(w);
		end
		expected_factors[expected_factors.size() - 1].last = 1'b1;
	endtask

	// Mostly smooth numbers, so that trial division stays short; the rest are
	// negative words with random low bits, zero, one and small integers.
	function automatic logic [DW-1:0] pick_value();
		int unsigned     kind;
		int unsigned     terms;
		longint unsigned acc;
		longint unsigned f;
		kind = $urandom_range(0, 99);
		if (kind < 12)
			return $urandom() | 32'h8000_0000;
		if (kind < 18)
			return $urandom_range(0, 1);
		if (kind < 28)
			return $urandom_range(2, 20000);
		acc = 1;
		terms = $urandom_range(1, 12);
		repeat (terms) begin
			f = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 300) : $urandom_range(2, 40);
			if (acc * f <= MaxPositive)
				acc = acc * f;
		end
		if ($urandom_range(0, 2) == 0) begin
			f = $urandom_range(2, 60000);
			if (acc * f <= MaxPositive)
				acc = acc * f;
		end
		return acc[DW-1:0];
	endfunction

	// Presents one word and returns at the edge where it is taken.
	task automatic send_word(input logic [DW-1:0] v);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 6000;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		factor_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			factors_checked++;
			if (expected_factors.size() == 0) begin
				$error("unexpected word: factor %0d last %0b none %0b", factor, last, none);
				mismatches++;
			end else begin
				want = expected_factors.pop_front();
				if (factor !== want.factor) begin
					$error("factor: expected %0d, got %0d", want.factor, factor);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
				if (none !== want.none) begin
					$error("none: expected %0b, got %0b", want.none, none);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [DW-1:0] v;
		// Rows with typed set carry their single result word; the rest go
		// through the predictor.
		directed_rows = '{
			'{32'h8000_0000, 1'b1, 31'd0, 1'b1},
			'{32'hFFFF_FFFF, 1'b1, 31'd0, 1'b1},
			'{32'hAAAA_AAAA, 1'b1, 31'd0, 1'b1},
			'{32'd0, 1'b1, 31'd0, 1'b1},
			'{32'd1, 1'b1, 31'd0, 1'b1},
			'{32'd2, 1'b1, 31'd2, 1'b0},
			'{32'd3, 1'b1, 31'd3, 1'b0},
			'{32'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 1'b0},
			'{32'h4000_0000, 1'b0, 31'd0, 1'b0},
			'{32'h7FFF_FFFE, 1'b0, 31'd0, 1'b0},
			'{32'h5555_5555, 1'b0, 31'd0, 1'b0},
			'{32'd4, 1'b0, 31'd0, 1'b0},
			'{32'd12, 1'b0, 31'd0, 1'b0},
			'{32'd49, 1'b0, 31'd0, 1'b0},
			'{32'd65521, 1'b0, 31'd0, 1'b0},
			'{32'd510510, 1'b0, 31'd0, 1'b0},
			'{32'd999983, 1'b0, 31'd0, 1'b0},
			'{32'd1000000, 1'b0, 31'd0, 1'b0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed)
				expected_factors.push_back('{factor: directed_rows[i].factor, last: 1'b1,
					none: directed_rows[i].none});
			else
				push_factorization(directed_rows[i].value);
			send_word(directed_rows[i].value);
		end

		for (int n = 0; n < RandomWords; n++) begin
			if (n == RandomWords / 3) begin
				send_idle_pct = 66;
				recv_stall_pct = 31;
			end
			if (n == 2 * RandomWords / 3) begin
				// No idling from here on; the output side first holds off for
				// a long stretch so that the core backs up into its input.
				send_idle_pct = 0;
				recv_stall_pct = 0;
				hold_request = 1'b1;
			end
			v = pick_value();
			push_factorization(v);
			send_word(v);
		end
		item_valid <= 1'b0;

		while (expected_factors.size() != 0)
			@(posedge clk);
		repeat (4 * DW + 16) @(posedge clk);

		$display("Sent %0d words (%0d directed: sign extremes, zero, one, primes, powers of two).",
			words_sent, DirectedWords);
		$display("Checked %0d factor words across three idle/stall mixes and one long hold-off.",
			factors_checked);
		if (mismatches == 0)
			$display("[prime_factorization_core] OK");
		else
			$display("[prime_factorization_core] ERROR");
		$finish;
	end

endmodule
